FILE: design/mtr_pkg.sv
// ----------------------------------------------------------------------------
// mtr_pkg: shared types and constants of the multipacket transport receiver
// Control codes, accepted group numbers, result kinds and the command and
// result records passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mtr_pkg;

  // Sizing
  localparam int MAX_MSG_BYTES = 2048;
  localparam int CHANNELS      = 2;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Connection-management control bytes
  localparam logic [7:0] CTRL_RTS   = 8'h10;
  localparam logic [7:0] CTRL_ABORT = 8'hFF;
  localparam logic [7:0] CTRL_CTS   = 8'h11;
  localparam logic [7:0] CTRL_EOM   = 8'h13;

  // Outgoing frame CAN id
  localparam logic [31:0] TX_CAN_ID = 32'h9CEC_F456;

  // Accepted parameter group numbers
  localparam logic [23:0] PGN_A = 24'h000200;
  localparam logic [23:0] PGN_B = 24'h000600;
  localparam logic [23:0] PGN_C = 24'h001100;
  localparam logic [23:0] PGN_D = 24'h001500;
  localparam logic [23:0] PGN_E = 24'h001600;
  localparam logic [23:0] PGN_F = 24'h001700;

  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [2:0] FRAME_BYTES = 3'd7;

  // Result kinds
  localparam logic [1:0] KIND_CTS     = 2'd0;
  localparam logic [1:0] KIND_EOM     = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_CTS,
    CMD_DATA,
    CMD_DATA_FINAL
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t         op;
    logic            ch;
    logic [10:0]     offset;
    logic [2:0]      count;
    logic [6:0][7:0] bytes;   // index 0 is out_byte1
    logic [15:0]     length;
    logic [7:0]      total;
    logic [23:0]     group;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic            ch;
    logic [10:0]     offset;
    logic [2:0]      count;
    logic            last;
    logic [6:0][7:0] bytes;   // index 0 is out_byte1
  } result_t;

endpackage

`default_nettype wire

FILE: design/mtr_front.sv
// ----------------------------------------------------------------------------
// mtr_front: frame classifier and per-channel session state
// Accepts one frame per cycle while the queue has room, updates the session
// of its channel and pushes a command for every frame that yields results.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_front
  import mtr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic            operation,
  input  wire logic            channel,
  input  wire logic [7:0][7:0] frame,      // index 0 is frame_byte0
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic        session_enabled      [CHANNELS];
  logic [15:0] message_length       [CHANNELS];
  logic [7:0]  packet_total         [CHANNELS];
  logic [15:0] bytes_received       [CHANNELS];
  logic [7:0]  expected_sequence    [CHANNELS];
  logic [23:0] group_number         [CHANNELS];

  logic        session_enabled_next   [CHANNELS];
  logic [15:0] message_length_next    [CHANNELS];
  logic [7:0]  packet_total_next      [CHANNELS];
  logic [15:0] bytes_received_next    [CHANNELS];
  logic [7:0]  expected_sequence_next [CHANNELS];
  logic [23:0] group_number_next      [CHANNELS];

  logic [23:0] req_group;
  logic [15:0] req_length;
  logic        group_ok;
  logic        length_ok;
  logic        channel_ok;
  logic [15:0] remain;
  logic        final_frame;
  logic [2:0]  take;

  // Decode the request fields and the data frame bookkeeping
  always_comb begin
    req_group   = {frame[5], frame[6], frame[7]};
    req_length  = {frame[2], frame[1]};
    group_ok    = req_group inside {PGN_A, PGN_B, PGN_C, PGN_D, PGN_E, PGN_F};
    length_ok   = req_length <= 16'(MAX_MSG_BYTES);
    channel_ok  = 32'(channel) < CHANNELS;
    remain      = message_length[channel] - bytes_received[channel];
    final_frame = remain <= 16'(FRAME_BYTES);
    take        = final_frame ? remain[2:0] : FRAME_BYTES;
  end

  // Classify the transaction, update its session and build the command
  always_comb begin
    session_enabled_next   = session_enabled;
    message_length_next    = message_length;
    packet_total_next      = packet_total;
    bytes_received_next    = bytes_received;
    expected_sequence_next = expected_sequence;
    group_number_next      = group_number;
    push                   = 1'b0;
    push_cmd.op            = CMD_DATA;
    push_cmd.ch            = channel;
    push_cmd.offset        = bytes_received[channel][10:0];
    push_cmd.count         = take;
    push_cmd.length        = message_length[channel];
    push_cmd.total         = packet_total[channel];
    push_cmd.group         = group_number[channel];
    for (int i = 0; i < 7; i++) begin
      push_cmd.bytes[i] = (3'(i) < take) ? frame[i + 1] : 8'h00;
    end

    if (accept && channel_ok) begin
      if (!operation) begin
        if (frame[0] == CTRL_RTS) begin
          if (group_ok) begin
            message_length_next[channel]    = req_length;
            packet_total_next[channel]      = frame[3];
            bytes_received_next[channel]    = 16'd0;
            expected_sequence_next[channel] = 8'd1;
            group_number_next[channel]      = req_group;
            session_enabled_next[channel]   = length_ok;
            if (length_ok) begin
              push            = 1'b1;
              push_cmd.op     = CMD_CTS;
              push_cmd.offset = 11'd0;
              push_cmd.count  = FRAME_BYTES;
              push_cmd.bytes  = {req_group[7:0], req_group[15:8], req_group[23:16],
                                 FILL_BYTE, FILL_BYTE, 8'd1, frame[3]};
            end
          end
        end else if (frame[0] == CTRL_ABORT) begin
          session_enabled_next[channel] = 1'b0;
        end
      end else if (session_enabled[channel] &&
                   frame[0] == expected_sequence[channel] &&
                   expected_sequence[channel] <= packet_total[channel]) begin
        push                         = 1'b1;
        push_cmd.op                  = final_frame ? CMD_DATA_FINAL : CMD_DATA;
        bytes_received_next[channel] = bytes_received[channel] + 16'(take);
        if (final_frame) begin
          session_enabled_next[channel] = 1'b0;
        end else begin
          expected_sequence_next[channel] = expected_sequence[channel] + 8'd1;
        end
      end
    end
  end

  // Hold the session registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        session_enabled[c]   <= 1'b0;
        message_length[c]    <= 16'd0;
        packet_total[c]      <= 8'd0;
        bytes_received[c]    <= 16'd0;
        expected_sequence[c] <= 8'd0;
        group_number[c]      <= 24'd0;
      end
    end else begin
      session_enabled   <= session_enabled_next;
      message_length    <= message_length_next;
      packet_total      <= packet_total_next;
      bytes_received    <= bytes_received_next;
      expected_sequence <= expected_sequence_next;
      group_number      <= group_number_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/mtr_queue.sv
// ----------------------------------------------------------------------------
// mtr_queue: short command queue between front end and back end
// Holds up to QUEUE_DEPTH commands; the head is visible without a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_queue
  import mtr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = fill == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty = fill == '0;
  assign head  = entry[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/mtr_back.sv
// ----------------------------------------------------------------------------
// mtr_back: result builder with output register
// Turns each queued command into one result, or into a payload result and
// an end-of-message acknowledgement for the final data frame.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_back
  import mtr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      head,
  input  wire logic empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_res
);

  logic    eom_pending;
  logic    eom_pending_next;
  logic    out_valid_next;
  result_t out_res_next;
  logic    load;

  assign load = !out_valid || out_ready;

  // Choose the next result
  always_comb begin
    pop              = 1'b0;
    eom_pending_next = eom_pending;
    out_valid_next   = out_valid;
    out_res_next     = out_res;
    if (load) begin
      out_valid_next = 1'b0;
      if (!empty) begin
        out_valid_next      = 1'b1;
        out_res_next.ch     = head.ch;
        out_res_next.offset = head.offset;
        out_res_next.count  = head.count;
        out_res_next.bytes  = head.bytes;
        out_res_next.last   = 1'b1;
        out_res_next.kind   = KIND_PAYLOAD;
        if (eom_pending) begin
          // second result of a final data frame
          out_res_next.kind   = KIND_EOM;
          out_res_next.offset = 11'd0;
          out_res_next.count  = FRAME_BYTES;
          out_res_next.bytes  = {head.group[7:0], head.group[15:8], head.group[23:16],
                                 FILL_BYTE, head.total, head.length[15:8],
                                 head.length[7:0]};
          eom_pending_next    = 1'b0;
          pop                 = 1'b1;
        end else begin
          case (head.op)
            CMD_CTS: begin
              out_res_next.kind = KIND_CTS;
              pop               = 1'b1;
            end
            CMD_DATA: begin
              pop = 1'b1;
            end
            CMD_DATA_FINAL: begin
              out_res_next.last = 1'b0;
              eom_pending_next  = 1'b1;
            end
            default: begin
              out_valid_next = 1'b0;
              pop            = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      eom_pending <= 1'b0;
    end else begin
      out_valid   <= out_valid_next;
      eom_pending <= eom_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    out_res <= out_res_next;
  end

endmodule

`default_nettype wire

FILE: design/multipacket_transport_receiver.sv
// ----------------------------------------------------------------------------
// multipacket_transport_receiver: receive side of a multi-packet transport
// One session per channel: requests open sessions and are answered with
// clear-to-send, data frames deliver payload with its byte offset, and the
// final frame adds an end-of-message acknowledgement.
//
//   channel | direction | tdata                          | tuser / tlast
//   --------+-----------+--------------------------------+------------------
//   s_*     | in        | frame_byte0..frame_byte7       | operation, channel
//   m_*     | out       | byte_offset, byte_count,       | kind, channel_out
//           |           | out_byte1..out_byte7           | tlast = last
//
// A frame is classified and its session updated in the cycle it is accepted;
// frames can arrive every cycle while the two-entry command queue has room.
// The back end emits one result per cycle unless m_tready stalls it; a final
// data frame yields two results there (payload, then acknowledgement).
// Synchronous reset clears all sessions, the queue and the output register.
// A stalled m_tready fills the queue and then drops s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module multipacket_transport_receiver
  import mtr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // frame_byte0 .. frame_byte7
  input  wire logic [1:0]  s_tuser,   // operation, channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // byte_offset, byte_count, out_byte1 .. out_byte7, zero pad
  output logic [2:0]       m_tuser,   // kind, channel_out
  output logic             m_tlast
);

  logic    accept;
  logic    push;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    q_full;
  logic    q_empty;
  logic    pop;
  result_t res;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  mtr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (s_tuser[0]),
    .channel   (s_tuser[1]),
    .frame     (s_tdata),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  mtr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  mtr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Pack the result transaction
  assign m_tdata = {2'b00, res.bytes, res.count, res.offset};
  assign m_tuser = {res.ch, res.kind};
  assign m_tlast = res.last;

`ifndef SYNTHESIS
  // A payload that is not last is followed at once by its acknowledgement
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser[1:0] == KIND_PAYLOAD && !m_tlast
    |=> m_tvalid && m_tuser[1:0] == KIND_EOM && m_tlast)
    else $error("payload without following acknowledgement");

  // Frame results always carry a full frame and no offset
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != KIND_PAYLOAD
    |-> m_tdata[13:11] == FRAME_BYTES && m_tdata[10:0] == 11'd0 && m_tlast)
    else $error("malformed frame result");

  // No result is valid right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // The queue never overflows: a full queue refuses input
  assert property (@(posedge clk) disable iff (rst)
    q_full |-> !accept)
    else $error("transaction accepted while queue full");
`endif

endmodule

`default_nettype wire
